// ===== rtl/core/saq_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Sorted alarm queue package
// Shared sizes, word types, opcodes and controller codes.
// ----------------------------------------------------------------------------
package saq_pkg;

  localparam int QUEUE_DEPTH = 32;
  localparam int ID_BITS     = 16;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int CMP_W       = (ID_BITS > 16) ? ID_BITS : 16;

  typedef enum logic [2:0] {
    OP_SET          = 3'd0,
    OP_CANCEL_ID    = 3'd1,
    OP_CANCEL_AGENT = 3'd2,
    OP_CANCEL_MATCH = 3'd3,
    OP_ACTIVE       = 3'd4,
    OP_PERIOD       = 3'd5,
    OP_PEEK         = 3'd6,
    OP_POP          = 3'd7
  } op_e;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_INVAL = 2'd2,
    STAT_NONE  = 2'd3
  } stat_e;

  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_INSERT,
    CMD_REMOVE,
    CMD_QUERY,
    CMD_EXPIRE,
    CMD_TAKE,
    CMD_EMIT
  } cmd_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_TAKE,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic [2:0]         opcode;
    logic [15:0]        agent_number;
    logic [31:0]        due_time;
    logic [15:0]        tag_value;
    logic signed [31:0] payload_value;
    logic [15:0]        target_id;
    logic [31:0]        current_time;
  } in_t;

  typedef struct packed {
    logic [1:0]         status_code;
    logic               hit_flag;
    logic [15:0]        result_id;
    logic [15:0]        result_agent;
    logic [31:0]        result_time;
    logic [15:0]        result_tag;
    logic signed [31:0] result_payload;
    logic [31:0]        seconds_left;
  } out_t;

  typedef struct packed {
    op_e  op;
    logic found;
    logic out_free;
  } dp_stat_t;

  function automatic logic [15:0] id_to_word(input logic [ID_BITS-1:0] v);
    logic [CMP_W-1:0] t;
    t = CMP_W'(v);
    return t[15:0];
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/saq_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Sorted alarm queue controller
// Sequences the datapath commands for each accepted word.
// ----------------------------------------------------------------------------
module saq_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  saq_pkg::dp_stat_t      stat_i,
  output saq_pkg::cmd_e          cmd_o
);

  saq_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= saq_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      saq_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = saq_pkg::ST_EXEC;
      end
      saq_pkg::ST_EXEC: begin
        case (stat_i.op)
          saq_pkg::OP_CANCEL_AGENT,
          saq_pkg::OP_CANCEL_MATCH: begin
            state_d = stat_i.found ? saq_pkg::ST_EXEC : saq_pkg::ST_DONE;
          end
          saq_pkg::OP_PEEK,
          saq_pkg::OP_POP: state_d = saq_pkg::ST_TAKE;
          default: state_d = saq_pkg::ST_DONE;
        endcase
      end
      saq_pkg::ST_TAKE: state_d = saq_pkg::ST_DONE;
      saq_pkg::ST_DONE: begin
        if (stat_i.out_free) state_d = saq_pkg::ST_IDLE;
      end
      default: state_d = saq_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = saq_pkg::CMD_NONE;
    in_ready_o = 1'b0;
    case (state_q)
      saq_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) cmd_o = saq_pkg::CMD_LOAD;
      end
      saq_pkg::ST_EXEC: begin
        case (stat_i.op)
          saq_pkg::OP_SET: cmd_o = saq_pkg::CMD_INSERT;
          saq_pkg::OP_CANCEL_ID,
          saq_pkg::OP_CANCEL_AGENT,
          saq_pkg::OP_CANCEL_MATCH: cmd_o = saq_pkg::CMD_REMOVE;
          saq_pkg::OP_ACTIVE,
          saq_pkg::OP_PERIOD: cmd_o = saq_pkg::CMD_QUERY;
          default: cmd_o = saq_pkg::CMD_EXPIRE;
        endcase
      end
      saq_pkg::ST_TAKE: cmd_o = saq_pkg::CMD_TAKE;
      saq_pkg::ST_DONE: begin
        if (stat_i.out_free) cmd_o = saq_pkg::CMD_EMIT;
      end
      default: cmd_o = saq_pkg::CMD_NONE;
    endcase
  end

endmodule
`default_nettype wire

// ===== rtl/core/saq_datapath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Sorted alarm queue datapath
// Row of alarm cells with insert, remove, expire and result logic.
// ----------------------------------------------------------------------------
module saq_datapath (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  saq_pkg::in_t        in_data_i,
  input  saq_pkg::cmd_e       cmd_i,
  output saq_pkg::dp_stat_t   stat_o,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  output saq_pkg::out_t       out_data_o
);

  localparam int N = saq_pkg::QUEUE_DEPTH;

  logic [31:0]               due_q [N];
  logic [31:0]               due_d [N];
  logic [saq_pkg::ID_BITS-1:0] id_q [N];
  logic [saq_pkg::ID_BITS-1:0] id_d [N];
  logic [15:0]               agent_q [N];
  logic [15:0]               agent_d [N];
  logic [15:0]               tag_q [N];
  logic [15:0]               tag_d [N];
  logic [31:0]               pay_q [N];
  logic [31:0]               pay_d [N];
  logic [N-1:0]              exp_q, exp_d;

  logic [saq_pkg::CNT_W-1:0] cnt_q, cnt_d;
  logic [saq_pkg::ID_BITS-1:0] next_id_q, next_id_d;
  logic                      any_q, any_d;
  logic                      out_valid_q;
  saq_pkg::in_t              in_q, in_d;
  saq_pkg::out_t             res_q, res_d, out_q, out_d;

  logic [N-1:0]              valid, ge, ins_here, match, shift, run;
  logic [31:0]               prev_due;
  logic                      prev_exp, next_exp, new_exp;
  logic                      key_ok, found, acc;
  logic [saq_pkg::ID_BITS-1:0] new_id;
  logic [saq_pkg::CMP_W-1:0] tid_ext;

  always_comb begin
    tid_ext = saq_pkg::CMP_W'(in_q.target_id);
    for (int k = 0; k < N; k++) begin
      valid[k] = cnt_q > saq_pkg::CNT_W'(k);
      ge[k]    = valid[k] && (in_q.due_time >= due_q[k]);
      case (saq_pkg::op_e'(in_q.opcode))
        saq_pkg::OP_CANCEL_ID,
        saq_pkg::OP_ACTIVE: match[k] = valid[k] &&
                                       (saq_pkg::CMP_W'(id_q[k]) == tid_ext);
        saq_pkg::OP_CANCEL_MATCH: match[k] = valid[k] &&
                                       (agent_q[k] == in_q.agent_number) &&
                                       (tag_q[k] == in_q.tag_value) &&
                                       (pay_q[k] == in_q.payload_value);
        default: match[k] = valid[k] && (agent_q[k] == in_q.agent_number);
      endcase
    end
    ins_here = ~ge & {ge[N-2:0], 1'b1};
    acc = 1'b0;
    for (int k = 0; k < N; k++) begin
      acc      = acc | match[k];
      shift[k] = acc;
    end
    acc = 1'b1;
    for (int k = 0; k < N; k++) begin
      acc    = acc & valid[k] & (in_q.current_time >= due_q[k]);
      run[k] = acc;
    end
    prev_due = '0;
    for (int k = 1; k < N; k++) begin
      prev_due = prev_due | ({32{ins_here[k]}} & due_q[k-1]);
    end
    prev_exp = |(ins_here[N-1:1] & exp_q[N-2:0]);
    next_exp = |(ins_here & exp_q & valid);
    if (cnt_q == '0) begin
      new_exp = (in_q.due_time == '0);
    end else if (ins_here[0]) begin
      new_exp = exp_q[0];
    end else if (in_q.due_time != '0) begin
      new_exp = (prev_due == in_q.due_time) ? prev_exp : next_exp;
    end else begin
      new_exp = 1'b1;
    end
    case (saq_pkg::op_e'(in_q.opcode))
      saq_pkg::OP_CANCEL_ID,
      saq_pkg::OP_ACTIVE: key_ok = (in_q.target_id != '0);
      default: key_ok = (in_q.agent_number != '0);
    endcase
    found  = key_ok && (|match);
    new_id = (next_id_q == '0) ? saq_pkg::ID_BITS'(1) : next_id_q;
  end

  always_comb begin
    due_d     = due_q;
    id_d      = id_q;
    agent_d   = agent_q;
    tag_d     = tag_q;
    pay_d     = pay_q;
    exp_d     = exp_q;
    cnt_d     = cnt_q;
    next_id_d = next_id_q;
    any_d     = any_q;
    in_d      = in_q;
    res_d     = res_q;
    out_d     = out_q;
    case (cmd_i)
      saq_pkg::CMD_LOAD: begin
        in_d  = in_data_i;
        res_d = '0;
        any_d = 1'b0;
      end
      saq_pkg::CMD_INSERT: begin
        if (in_q.agent_number == '0) begin
          res_d.status_code = saq_pkg::STAT_INVAL;
        end else if (cnt_q == saq_pkg::CNT_W'(N)) begin
          res_d.status_code = saq_pkg::STAT_FULL;
        end else begin
          for (int k = 1; k < N; k++) begin
            if (!ge[k] && !ins_here[k]) begin
              due_d[k]   = due_q[k-1];
              id_d[k]    = id_q[k-1];
              agent_d[k] = agent_q[k-1];
              tag_d[k]   = tag_q[k-1];
              pay_d[k]   = pay_q[k-1];
              exp_d[k]   = exp_q[k-1];
            end
          end
          for (int k = 0; k < N; k++) begin
            if (ins_here[k]) begin
              due_d[k]   = in_q.due_time;
              id_d[k]    = new_id;
              agent_d[k] = in_q.agent_number;
              tag_d[k]   = in_q.tag_value;
              pay_d[k]   = in_q.payload_value;
              exp_d[k]   = new_exp;
            end
          end
          cnt_d           = cnt_q + 1'b1;
          next_id_d       = new_id + 1'b1;
          res_d.result_id = saq_pkg::id_to_word(new_id);
        end
      end
      saq_pkg::CMD_REMOVE: begin
        if (!key_ok) begin
          res_d.status_code = saq_pkg::STAT_INVAL;
        end else begin
          if (found) begin
            for (int k = 0; k < N - 1; k++) begin
              if (shift[k]) begin
                due_d[k]   = due_q[k+1];
                id_d[k]    = id_q[k+1];
                agent_d[k] = agent_q[k+1];
                tag_d[k]   = tag_q[k+1];
                pay_d[k]   = pay_q[k+1];
                exp_d[k]   = exp_q[k+1];
              end
            end
            cnt_d = cnt_q - 1'b1;
            any_d = 1'b1;
          end
          res_d.status_code = (any_q || found) ? saq_pkg::STAT_OK : saq_pkg::STAT_NONE;
        end
      end
      saq_pkg::CMD_QUERY: begin
        if (saq_pkg::op_e'(in_q.opcode) == saq_pkg::OP_ACTIVE) begin
          if (!key_ok) begin
            res_d.status_code = saq_pkg::STAT_INVAL;
          end else if (found) begin
            res_d.hit_flag = 1'b1;
          end else begin
            res_d.status_code = saq_pkg::STAT_NONE;
          end
        end else begin
          if (cnt_q == '0) begin
            res_d.status_code = saq_pkg::STAT_NONE;
          end else if (due_q[0] > in_q.current_time) begin
            res_d.seconds_left = due_q[0] - in_q.current_time;
          end
        end
      end
      saq_pkg::CMD_EXPIRE: begin
        if (cnt_q != '0 && !exp_q[0]) exp_d = exp_q | run;
      end
      saq_pkg::CMD_TAKE: begin
        if (cnt_q == '0) begin
          res_d.status_code = saq_pkg::STAT_NONE;
        end else if (exp_q[0]) begin
          res_d.hit_flag       = 1'b1;
          res_d.result_id      = saq_pkg::id_to_word(id_q[0]);
          res_d.result_agent   = agent_q[0];
          res_d.result_time    = due_q[0];
          res_d.result_tag     = tag_q[0];
          res_d.result_payload = pay_q[0];
          if (saq_pkg::op_e'(in_q.opcode) == saq_pkg::OP_POP) begin
            for (int k = 0; k < N - 1; k++) begin
              due_d[k]   = due_q[k+1];
              id_d[k]    = id_q[k+1];
              agent_d[k] = agent_q[k+1];
              tag_d[k]   = tag_q[k+1];
              pay_d[k]   = pay_q[k+1];
              exp_d[k]   = exp_q[k+1];
            end
            cnt_d = cnt_q - 1'b1;
          end
        end
      end
      saq_pkg::CMD_EMIT: out_d = res_q;
      default: out_d = out_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    due_q   <= due_d;
    id_q    <= id_d;
    agent_q <= agent_d;
    tag_q   <= tag_d;
    pay_q   <= pay_d;
    exp_q   <= exp_d;
    in_q    <= in_d;
    res_q   <= res_d;
    out_q   <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      next_id_q   <= saq_pkg::ID_BITS'(1);
      any_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q     <= cnt_d;
      next_id_q <= next_id_d;
      any_q     <= any_d;
      if (cmd_i == saq_pkg::CMD_EMIT) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign stat_o.op       = saq_pkg::op_e'(in_q.opcode);
  assign stat_o.found    = found;
  assign stat_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_o     = out_valid_q;
  assign out_data_o      = out_q;

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= saq_pkg::CNT_W'(N))
    else $error("Alarm count exceeds queue depth.");

  a_insert_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i == saq_pkg::CMD_INSERT && in_q.agent_number != '0 &&
     cnt_q != saq_pkg::CNT_W'(N)) |=> cnt_q == $past(cnt_q) + 1'b1)
    else $error("Insert did not grow the queue by one.");

  a_remove_shrinks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i == saq_pkg::CMD_REMOVE && found) |=> cnt_q == $past(cnt_q) - 1'b1)
    else $error("Remove did not shrink the queue by one.");

  a_emit_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i == saq_pkg::CMD_EMIT) |=> out_valid_q)
    else $error("Result word was not presented after emit.");

endmodule
`default_nettype wire

// ===== rtl/core/sorted_alarm_queue_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Sorted alarm queue unit
// Alarm queue ordered by due time with set, cancel, query and pop commands.
//
//   Channel | Direction | Handshake               | Word
//   in      | input     | in_valid_i / in_ready_o | saq_pkg::in_t
//   out     | output    | out_valid_o/out_ready_i | saq_pkg::out_t
//
// Set, cancel by id, active and period run an execute step and then wait in done
// until the output register is free; the controller then returns to idle for the next word.
// Peek and pop run an expire pass in the execute state and then a take step.
// Cancel by agent and cancel match remove one matching alarm per cycle and stay
// in the execute state until no further match is found.
// A new word is accepted while the previous result waits in the output register;
// a result that finds that register still occupied holds the controller.
// Reset clears the count and the id counter; no clearing pass is needed.
// ----------------------------------------------------------------------------
module sorted_alarm_queue_unit (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  input  saq_pkg::in_t   in_data_i,
  output logic           out_valid_o,
  input  wire logic      out_ready_i,
  output saq_pkg::out_t  out_data_o
);

  saq_pkg::cmd_e     cmd;
  saq_pkg::dp_stat_t stat;

  saq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  saq_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule
`default_nettype wire

// ===== sim/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Sorted alarm queue testbench
// Drives random and directed alarm commands through the valid/ready input,
// predicts every result word with a behavioral queue model and compares
// each output word field by field, with random idling on both sides.
// ----------------------------------------------------------------------------
module testbench;

  localparam int WATCHDOG_LIMIT = 20000;

  logic           clk_i = 1'b0;
  logic           rst_ni = 1'b0;
  logic           in_valid_i = 1'b0;
  logic           in_ready_o;
  saq_pkg::in_t   in_data_i = '0;
  logic           out_valid_o;
  logic           out_ready_i = 1'b0;
  saq_pkg::out_t  out_data_o;

  sorted_alarm_queue_unit dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_ready_o(in_ready_o), .in_data_i(in_data_i),
    .out_valid_o(out_valid_o), .out_ready_i(out_ready_i), .out_data_o(out_data_o)
  );

  always #4 clk_i = ~clk_i;

  // Behavioral copy of the alarm queue.
  logic [31:0] q_due[saq_pkg::QUEUE_DEPTH];
  logic [15:0] q_id[saq_pkg::QUEUE_DEPTH];
  logic [15:0] q_agent[saq_pkg::QUEUE_DEPTH];
  logic [15:0] q_tag[saq_pkg::QUEUE_DEPTH];
  logic [31:0] q_pay[saq_pkg::QUEUE_DEPTH];
  logic        q_exp[saq_pkg::QUEUE_DEPTH];
  int          q_count = 0;
  logic [15:0] q_next_id = 16'd1;

  saq_pkg::in_t  pending_words[$];
  saq_pkg::out_t expected_words[$];
  int   mismatches = 0;
  bit   stall_long = 0;
  bit   stim_done = 0;

  function automatic void drop_slot(int pos);
    for (int k = pos; k + 1 < q_count; k++) begin
      q_due[k] = q_due[k+1]; q_id[k] = q_id[k+1]; q_agent[k] = q_agent[k+1];
      q_tag[k] = q_tag[k+1]; q_pay[k] = q_pay[k+1]; q_exp[k] = q_exp[k+1];
    end
    if (q_count > 0) q_count--;
  endfunction

  function automatic saq_pkg::out_t predict_alarm(saq_pkg::in_t w);
    saq_pkg::out_t r;
    int pos;
    int k;
    logic ex;
    bit any;
    bit m;
    r = '0;
    case (saq_pkg::op_e'(w.opcode))
      saq_pkg::OP_SET: begin
        if (w.agent_number == 0) r.status_code = saq_pkg::STAT_INVAL;
        else if (q_count >= saq_pkg::QUEUE_DEPTH) r.status_code = saq_pkg::STAT_FULL;
        else begin
          ex = (w.due_time == 0);
          if (q_next_id == 16'd0) q_next_id = 16'd1;
          r.result_id = q_next_id;
          q_next_id = q_next_id + 16'd1;
          if (q_count == 0) pos = 0;
          else if (w.due_time < q_due[0]) begin
            pos = 0; ex = q_exp[0];
          end else begin
            pos = 1;
            while (pos < q_count && w.due_time >= q_due[pos]) pos++;
            if (w.due_time != 0) begin
              if (q_due[pos-1] == w.due_time) ex = q_exp[pos-1];
              else if (pos < q_count) ex = q_exp[pos];
            end
          end
          for (k = q_count; k > pos; k--) begin
            q_due[k] = q_due[k-1]; q_id[k] = q_id[k-1]; q_agent[k] = q_agent[k-1];
            q_tag[k] = q_tag[k-1]; q_pay[k] = q_pay[k-1]; q_exp[k] = q_exp[k-1];
          end
          q_due[pos] = w.due_time; q_id[pos] = r.result_id;
          q_agent[pos] = w.agent_number; q_tag[pos] = w.tag_value;
          q_pay[pos] = w.payload_value; q_exp[pos] = ex;
          q_count++;
        end
      end
      saq_pkg::OP_CANCEL_ID, saq_pkg::OP_ACTIVE: begin
        if (w.target_id == 0) r.status_code = saq_pkg::STAT_INVAL;
        else begin
          r.status_code = saq_pkg::STAT_NONE;
          for (k = 0; k < q_count; k++) begin
            if (q_id[k] == w.target_id) begin
              r.status_code = saq_pkg::STAT_OK;
              if (w.opcode == saq_pkg::OP_ACTIVE) r.hit_flag = 1'b1;
              else drop_slot(k);
              break;
            end
          end
        end
      end
      saq_pkg::OP_CANCEL_AGENT, saq_pkg::OP_CANCEL_MATCH: begin
        if (w.agent_number == 0) r.status_code = saq_pkg::STAT_INVAL;
        else begin
          any = 0;
          k = 0;
          while (k < q_count) begin
            m = (q_agent[k] == w.agent_number);
            if (w.opcode == saq_pkg::OP_CANCEL_MATCH)
              m = m && q_tag[k] == w.tag_value && q_pay[k] == w.payload_value;
            if (m) begin
              drop_slot(k); any = 1;
            end else k++;
          end
          r.status_code = any ? saq_pkg::STAT_OK : saq_pkg::STAT_NONE;
        end
      end
      saq_pkg::OP_PERIOD: begin
        if (q_count == 0) r.status_code = saq_pkg::STAT_NONE;
        else if (q_due[0] > w.current_time) r.seconds_left = q_due[0] - w.current_time;
      end
      default: begin
        if (q_count == 0) r.status_code = saq_pkg::STAT_NONE;
        else begin
          if (!q_exp[0])
            for (k = 0; k < q_count && w.current_time >= q_due[k]; k++) q_exp[k] = 1'b1;
          if (q_exp[0]) begin
            r.hit_flag = 1'b1; r.result_id = q_id[0]; r.result_agent = q_agent[0];
            r.result_time = q_due[0]; r.result_tag = q_tag[0];
            r.result_payload = q_pay[0];
            if (w.opcode == saq_pkg::OP_POP) drop_slot(0);
          end
        end
      end
    endcase
    return r;
  endfunction

  // Driver.
  int send_gap = 0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) expected_words.push_back(predict_alarm(in_data_i));
      if (!in_valid_i || in_ready_o) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          in_valid_i <= 1'b0;
        end else if (pending_words.size() > 0 && pending_words[0].opcode === 3'bx) begin
          // A marker word makes the sender pause until all expected result words have been received.
          in_valid_i <= 1'b0;
          if (expected_words.size() == 0 && !(in_valid_i && in_ready_o))
            void'(pending_words.pop_front());
        end else if (pending_words.size() > 0) begin
          in_data_i <= pending_words.pop_front();
          in_valid_i <= 1'b1;
          send_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7);
        end else begin
          in_valid_i <= 1'b0;
          stim_done <= 1'b1;
        end
      end
    end
  end

  // Monitor.
  int recv_gap = 0;
  always @(posedge clk_i) begin
    saq_pkg::out_t exp_w;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (expected_words.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("Unexpected result word %h", out_data_o);
        end else begin
          exp_w = expected_words.pop_front();
          if (exp_w !== out_data_o) begin
            mismatches++;
            if (mismatches <= 10)
              $display("Mismatch: expected %h, got %h", exp_w, out_data_o);
          end
        end
      end
      if (stall_long) out_ready_i <= 1'b0;
      else if (recv_gap > 0) begin
        recv_gap <= recv_gap - 1;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
        if (out_valid_o && out_ready_i)
          recv_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7);
      end
    end
  end

  // Watchdog.
  int idle_cycles = 0;
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Recently issued ids, approximated from the count of set words sent so far.
  int sets_sent = 0;
  function automatic logic [15:0] q_hint_id();
    int lo;
    lo = (sets_sent > 40) ? sets_sent - 40 : 1;
    return 16'($urandom_range(lo, sets_sent + 2));
  endfunction

  function automatic saq_pkg::in_t rand_word(bit well_formed);
    saq_pkg::in_t w;
    int r;
    w.opcode = 3'($urandom_range(0, 7));
    w.agent_number = well_formed ? 16'($urandom_range(1, 4)) : 16'($urandom);
    r = $urandom_range(0, 9);
    w.due_time = (r == 0) ? 32'd0 : (r == 1) ? 32'hFFFF_FFFF : 32'($urandom_range(1, 60));
    if (!well_formed) w.due_time = $urandom;
    w.tag_value = well_formed ? 16'($urandom_range(0, 1)) : 16'($urandom);
    w.payload_value = well_formed ? 32'($urandom_range(0, 1)) : $urandom;
    w.target_id = well_formed ? q_hint_id() : 16'($urandom);
    r = $urandom_range(0, 9);
    w.current_time = (r == 0) ? 32'hFFFF_FFFF : (r == 1) ? 32'd0 : 32'($urandom_range(0, 70));
    if (!well_formed) w.current_time = $urandom;
    if (well_formed && $urandom_range(0, 2) == 0) w.opcode = saq_pkg::OP_SET;
    return w;
  endfunction

  function automatic saq_pkg::in_t make_word(saq_pkg::op_e op, int agent, int due,
                                             int tag, int pay, int tid, int now);
    saq_pkg::in_t w;
    w.opcode = op; w.agent_number = 16'(agent); w.due_time = 32'(due);
    w.tag_value = 16'(tag); w.payload_value = 32'(pay); w.target_id = 16'(tid);
    w.current_time = 32'(now);
    return w;
  endfunction

  saq_pkg::in_t pause_word;
  initial begin
    saq_pkg::in_t w;
    pause_word = 'x;
    pending_words.push_back(make_word(saq_pkg::OP_PEEK, 1, 0, 0, 0, 0, 0));
    pending_words.push_back(make_word(saq_pkg::OP_PERIOD, 1, 0, 0, 0, 0, 0));
    pending_words.push_back(make_word(saq_pkg::OP_SET, 0, 5, 0, 0, 0, 0));
    pending_words.push_back(make_word(saq_pkg::OP_SET, 'hFFFF, 32'hFFFF_FFFF, 'hFFFF,
                                      32'h8000_0000, 0, 0));
    pending_words.push_back(make_word(saq_pkg::OP_SET, 1, 0, 'h1234, 32'h7FFF_FFFF, 0, 0));
    pending_words.push_back(make_word(saq_pkg::OP_SET, 2, 10, 3, 32'hFFFF_FFFF, 0, 0));
    pending_words.push_back(make_word(saq_pkg::OP_SET, 2, 10, 3, 5, 0, 0));
    pending_words.push_back(make_word(saq_pkg::OP_PERIOD, 0, 0, 0, 0, 0, 32'hFFFF_FFFF));
    pending_words.push_back(make_word(saq_pkg::OP_PEEK, 0, 0, 0, 0, 0, 10));
    pending_words.push_back(make_word(saq_pkg::OP_SET, 3, 10, 0, 0, 0, 0));
    pending_words.push_back(make_word(saq_pkg::OP_SET, 3, 4, 0, 0, 0, 0));
    pending_words.push_back(make_word(saq_pkg::OP_ACTIVE, 0, 0, 0, 0, 0, 0));
    pending_words.push_back(make_word(saq_pkg::OP_ACTIVE, 0, 0, 0, 0, 3, 0));
    pending_words.push_back(make_word(saq_pkg::OP_ACTIVE, 0, 0, 0, 0, 'hFFFF, 0));
    pending_words.push_back(make_word(saq_pkg::OP_CANCEL_ID, 0, 0, 0, 0, 0, 0));
    pending_words.push_back(make_word(saq_pkg::OP_CANCEL_ID, 0, 0, 0, 0, 2, 0));
    pending_words.push_back(make_word(saq_pkg::OP_CANCEL_ID, 0, 0, 0, 0, 2, 0));
    pending_words.push_back(make_word(saq_pkg::OP_CANCEL_MATCH, 2, 0, 3, 5, 0, 0));
    pending_words.push_back(make_word(saq_pkg::OP_CANCEL_MATCH, 0, 0, 3, 5, 0, 0));
    pending_words.push_back(make_word(saq_pkg::OP_CANCEL_AGENT, 3, 0, 0, 0, 0, 0));
    pending_words.push_back(make_word(saq_pkg::OP_CANCEL_AGENT, 0, 0, 0, 0, 0, 0));
    pending_words.push_back(make_word(saq_pkg::OP_POP, 0, 0, 0, 0, 0, 0));
    pending_words.push_back(make_word(saq_pkg::OP_POP, 0, 0, 0, 0, 0, 32'hFFFF_FFFF));
    pending_words.push_back(make_word(saq_pkg::OP_POP, 0, 0, 0, 0, 0, 32'hFFFF_FFFF));
    sets_sent = 8;
    // Fill the queue past its depth.
    for (int i = 0; i < 40; i++) begin
      pending_words.push_back(make_word(saq_pkg::OP_SET, 1 + i % 3,
                                        32'($urandom_range(1, 50)), 0, 0, 0, 0));
      sets_sent++;
    end
    pending_words.push_back(pause_word);
    for (int i = 0; i < 1290; i++) begin
      w = rand_word($urandom_range(0, 9) != 0);
      if (w.opcode == saq_pkg::OP_SET) sets_sent++;
      pending_words.push_back(w);
      if (i % 300 == 150) pending_words.push_back(pause_word);
    end
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (30) @(posedge clk_i);
    stall_long <= 1'b1;
    repeat (300) @(posedge clk_i);
    stall_long <= 1'b0;
    wait (stim_done && expected_words.size() == 0);
    repeat (50) @(posedge clk_i);
    if (mismatches == 0 && expected_words.size() == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end
endmodule
